// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the particle motion update RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== sv/pmu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmu_pkg: shared types and constants
// Transaction payloads, command and configuration structs, codes and the
// sequencer state type of the particle motion update block.
// ---------------------------------------------------------------------------
package pmu_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD       = 2'd0;
  localparam logic [1:0] OP_TICK       = 2'd1;
  localparam logic [1:0] OP_RESET_LIFE = 2'd2;
  localparam logic [1:0] OP_END_LOOP   = 2'd3;

  // Motion modes; codes above hold behave as hold.
  localparam logic [2:0] MODE_DROP     = 3'd0;
  localparam logic [2:0] MODE_RISE     = 3'd1;
  localparam logic [2:0] MODE_EXPLODE  = 3'd2;
  localparam logic [2:0] MODE_FRACTION = 3'd3;
  localparam logic [2:0] MODE_HOLD     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_LOOPING = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_PIVOT_X = 3'd3;
  localparam logic [2:0] REG_PIVOT_Y = 3'd4;
  localparam logic [2:0] REG_PIVOT_Z = 3'd5;
  localparam logic [2:0] REG_GRAVITY = 3'd6;

  // Fixed-point constants.
  localparam logic [30:0] GRAVITY_RESET = 31'd642253;
  localparam logic [12:0] Q_TENTH       = 13'd6554;
  localparam logic [15:0] Q_HALF        = 16'h8000;
  localparam logic [47:0] MAG_CAP       = 48'h8000_0000_0000;

  // Last iteration indexes of the square root and the divider.
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd16;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         particle_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [30:0]        move_speed;
    logic [30:0]        life_span;
    logic [30:0]        size_scale;
    logic [30:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         result_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_result;
    logic               all_finished;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         motion_mode;
    logic               looping;
    logic [6:0]         particle_count;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic [30:0]        gravity;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TICK,
    CMD_RESET_LIFE,
    CMD_END_LOOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [5:0]  index;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [30:0] speed;
    logic [30:0] life;
    logic [30:0] scale;
    logic [30:0] dt;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_SQRT,
    ST_LEN,
    ST_DIV,
    ST_MV,
    ST_SAG1,
    ST_SAG2,
    ST_UPD,
    ST_RL
  } pmu_state_t;

endpackage

// ===== sv/pmu_chan_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmu_chan_if: valid/ready channel
// Carries one payload per transaction from a source to a sink.
// ---------------------------------------------------------------------------
interface pmu_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/particle_motion_update_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_motion_update_top: particle table with fixed-point motion update
// Configuration registers, command queue and motion engine.
// ---------------------------------------------------------------------------
// A load, end-loop or reset-life transaction produces no result; load and
// end-loop are handled in the idle state, reset-life resets each particle
// in use. A tick produces one result per particle in use. In drop, rise
// and hold modes a tick takes each particle through memory read, product,
// rounding and write-back, which waits while the result register is full.
// Explosion and fraction modes add the one-bit-per-cycle square root and
// the three-lane restoring divider that normalize the direction. A
// two-entry command queue lets new transactions arrive while a tick runs,
// and a result register lets the engine work on the next particle while
// the previous result waits. Configuration may only be written while idle.
// ---------------------------------------------------------------------------
module particle_motion_update_top import pmu_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  pmu_chan_if.sink    in_ch,
  pmu_chan_if.source  out_ch
);

  cfg_t cfg_r;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_mode    <= MODE_DROP;
      cfg_r.looping        <= 1'b0;
      cfg_r.particle_count <= 7'd64;
      cfg_r.pivot_x        <= '0;
      cfg_r.pivot_y        <= '0;
      cfg_r.pivot_z        <= '0;
      cfg_r.gravity        <= GRAVITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    cfg_r.motion_mode    <= cfg_wdata[2:0];
        REG_LOOPING: cfg_r.looping        <= cfg_wdata[0];
        REG_COUNT:   cfg_r.particle_count <= cfg_wdata[6:0];
        REG_PIVOT_X: cfg_r.pivot_x        <= cfg_wdata;
        REG_PIVOT_Y: cfg_r.pivot_y        <= cfg_wdata;
        REG_PIVOT_Z: cfg_r.pivot_z        <= cfg_wdata;
        REG_GRAVITY: cfg_r.gravity        <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  pmu_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pmu_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/pmu_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmu_front: input classification and command queue
// Accepts input transactions, turns them into commands, drops loads aimed
// past the table and holds up to two commands for the execution engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmu_front import pmu_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  pmu_chan_if.sink   in_ch,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t            fifo_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r, cnt_nxt;
  in_item_t        item;
  cmd_t            new_cmd;
  logic            keep, push, pop;

  // Classify the incoming transaction.
  always_comb begin
    item          = in_ch.data;
    new_cmd.index = item.particle_index;
    new_cmd.sx    = item.start_x;
    new_cmd.sy    = item.start_y;
    new_cmd.sz    = item.start_z;
    new_cmd.speed = item.move_speed;
    new_cmd.life  = item.life_span;
    new_cmd.scale = item.size_scale;
    new_cmd.dt    = item.time_step;
    unique case (item.operation)
      OP_LOAD:       new_cmd.kind = CMD_LOAD;
      OP_TICK:       new_cmd.kind = CMD_TICK;
      OP_RESET_LIFE: new_cmd.kind = CMD_RESET_LIFE;
      OP_END_LOOP:   new_cmd.kind = CMD_END_LOOP;
      default:       new_cmd.kind = CMD_END_LOOP;
    endcase
    keep = (item.operation != OP_LOAD) ||
           (7'(item.particle_index) < 7'(MAX_PARTICLES));
  end

  assign in_ch.ready = (cnt_r != (PW+1)'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign pop         = cmd_pop && (cnt_r != '0);
  assign cnt_nxt     = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = fifo_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= new_cmd;
  end

  `ASSERT_NEVER(a_fifo_bound, cnt_r > (PW+1)'(DEPTH), "command queue overfilled")
  `ASSERT_CLK(a_pop_nonempty, cmd_pop |-> cnt_r != '0, "pop from empty command queue")

endmodule

// ===== sv/pmu_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmu_back: particle table and motion engine
// Executes queued commands against the particle memory: loads, life resets,
// loop end and ticks, with an iterative square root and divider for the
// explosion direction, and a registered result stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmu_back import pmu_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  pmu_chan_if.source out_ch
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

  typedef struct packed {
    logic [31:0] org_x;
    logic [31:0] org_y;
    logic [31:0] org_z;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [31:0] cur_z;
    logic [30:0] speed;
    logic [30:0] life;
    logic [31:0] age;
    logic [30:0] scale;
  } particle_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > S32_MAX)      r = 32'h7FFF_FFFF;
    else if (v < S32_MIN) r = 32'h8000_0000;
    else                  r = v[31:0];
    return r;
  endfunction

  // Particle memory.
  particle_t mem [MAX_PARTICLES];

  // Control state.
  pmu_state_t      state_r, state_nxt;
  logic [AW-1:0]   idx_r;
  logic            loop_ended_r, fin_r, out_valid_r;
  cmd_t            cmd_r;
  out_item_t       out_data_r;

  // Datapath registers.
  particle_t       ent_r;
  logic [61:0]     dprod_r, s1prod_r;
  logic [2:0]      neg_r;
  logic [2:0][31:0] mraw_r;
  logic [45:0]     d_r, s1_r;
  logic [2:0][30:0] ms_r;
  logic [2:0][61:0] sq_r;
  logic [58:0]     s2prod_r;
  logic [42:0]     s2_r;
  logic [63:0]     v_r, r_r, bit_r;
  logic [4:0]      step_r;
  logic [31:0]     len_r;
  logic [2:0][31:0] rem_r;
  logic [2:0][16:0] nsh_r, q_r;
  logic [2:0][62:0] mvp_r;
  logic [2:0][46:0] mv_r;
  logic [63:0]     plo_r;
  logic [42:0]     phi_r;
  logic [47:0]     sag_r;

  // Combinational signals.
  logic [2:0]      mode_e;
  logic            explode;
  logic [AW-1:0]   last_c;
  logic            is_last, out_free;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  particle_t       mem_wdata, upd_ent, rl_ent, load_ent;
  logic            fin_this;
  logic [2:0][32:0] diff_c, mag_c;
  logic [2:0][31:0] cur_v, piv_v;
  logic            big_c;
  logic [2:0][47:0] num_c;
  logic [2:0][32:0] rem2_c;
  logic [2:0]      ge_c;
  logic [63:0]     sq_t;
  logic [75:0]     sag_sum;
  logic [59:0]     sag_q;
  logic [61:0]     dsum, s1sum;
  logic [58:0]     s2sum;

  // Mode, particle count and stall decode.
  always_comb begin
    mode_e  = (cfg.motion_mode > MODE_HOLD) ? MODE_HOLD : cfg.motion_mode;
    explode = (mode_e == MODE_EXPLODE) || (mode_e == MODE_FRACTION);
    if (cfg.particle_count == 7'd0)                      last_c = '0;
    else if (cfg.particle_count > 7'(MAX_PARTICLES))     last_c = AW'(MAX_PARTICLES - 1);
    else                                                 last_c = AW'(cfg.particle_count - 7'd1);
    is_last  = (idx_r == last_c);
    out_free = !out_valid_r || out_ch.ready;
  end

  // Direction front end: offsets from the pivot and their magnitudes.
  always_comb begin
    cur_v = {ent_r.cur_z, ent_r.cur_y, ent_r.cur_x};
    piv_v = {cfg.pivot_z, cfg.pivot_y, cfg.pivot_x};
    for (int k = 0; k < 3; k++) begin
      diff_c[k] = {cur_v[k][31], cur_v[k]} - {piv_v[k][31], piv_v[k]};
      mag_c[k]  = diff_c[k][32] ? (33'd0 - diff_c[k]) : diff_c[k];
    end
    big_c = mraw_r[0][31] || mraw_r[1][31] || mraw_r[2][31];
  end

  // Rounding of the Q16.16 products.
  always_comb begin
    dsum  = dprod_r + 62'(Q_HALF);
    s1sum = s1prod_r + 62'(Q_HALF);
    s2sum = s2prod_r + 59'(Q_HALF);
    sq_t  = 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    sag_sum = {phi_r, 32'd0} + 76'(plo_r) + 76'(Q_HALF);
    sag_q   = sag_sum[75:16];
  end

  // Divider numerators and one restoring step per lane.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_c[k]  = {1'b0, ms_r[k], 16'd0} + 48'(r_r[31:1]);
      rem2_c[k] = {rem_r[k], nsh_r[k][16]};
      ge_c[k]   = (rem2_c[k] >= {1'b0, len_r});
    end
  end

  // Position, age and expiry update of the current particle.
  always_comb begin
    logic signed [49:0] cx, cy, cz, nx, ny, nz, ds, sgs;
    logic signed [2:0][49:0] mvs;
    logic [32:0] age_sum;
    logic [31:0] age_new;
    logic        expired, restart;
    cx  = 50'(signed'(ent_r.cur_x));
    cy  = 50'(signed'(ent_r.cur_y));
    cz  = 50'(signed'(ent_r.cur_z));
    ds  = signed'({4'd0, d_r});
    sgs = signed'({2'd0, sag_r});
    for (int k = 0; k < 3; k++) begin
      mvs[k] = neg_r[k] ? -signed'({3'd0, mv_r[k]}) : signed'({3'd0, mv_r[k]});
    end
    nx = cx;
    ny = cy;
    nz = cz;
    case (mode_e) inside
      MODE_DROP:                   ny = cy - ds;
      MODE_RISE:                   ny = cy + ds;
      MODE_EXPLODE, MODE_FRACTION: begin
        nx = cx + mvs[0];
        ny = cy + mvs[1] - sgs;
        nz = cz + mvs[2];
      end
      default: ;
    endcase
    age_sum = {1'b0, ent_r.age} + 33'(cmd_r.dt);
    age_new = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    expired = ({1'b0, ent_r.life} <= age_new);
    restart = expired && cfg.looping && !loop_ended_r;
    fin_this = expired ? !restart : loop_ended_r;

    upd_ent       = ent_r;
    upd_ent.cur_x = sat32(nx);
    upd_ent.cur_y = sat32(ny);
    upd_ent.cur_z = sat32(nz);
    upd_ent.age   = restart ? 32'd0 : age_new;
    if (restart) begin
      case (mode_e) inside
        MODE_DROP, MODE_RISE: upd_ent.cur_y = ent_r.org_y;
        MODE_EXPLODE, MODE_FRACTION: begin
          upd_ent.cur_x = ent_r.org_x;
          upd_ent.cur_y = ent_r.org_y;
          upd_ent.cur_z = ent_r.org_z;
        end
        default: ;
      endcase
    end

    rl_ent       = ent_r;
    rl_ent.cur_x = ent_r.org_x;
    rl_ent.cur_y = ent_r.org_y;
    rl_ent.cur_z = ent_r.org_z;
    rl_ent.age   = 32'd0;

    load_ent.org_x = cmd.sx;
    load_ent.org_y = cmd.sy;
    load_ent.org_z = cmd.sz;
    load_ent.cur_x = cmd.sx;
    load_ent.cur_y = cmd.sy;
    load_ent.cur_z = cmd.sz;
    load_ent.speed = cmd.speed;
    load_ent.life  = cmd.life;
    load_ent.age   = 32'd0;
    load_ent.scale = cmd.scale;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind) inside
            CMD_TICK, CMD_RESET_LIFE: state_nxt = ST_RD;
            default:                  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:   state_nxt = (cmd_r.kind == CMD_RESET_LIFE) ? ST_RL : ST_C1;
      ST_C1:   state_nxt = ST_C2;
      ST_C2:   state_nxt = explode ? ST_C3 : ST_UPD;
      ST_C3:   state_nxt = ST_C4;
      ST_C4:   state_nxt = ST_SQRT;
      ST_SQRT: if (step_r == SQRT_LAST) state_nxt = ST_LEN;
      ST_LEN:  state_nxt = ST_DIV;
      ST_DIV:  if (step_r == DIV_LAST) state_nxt = ST_MV;
      ST_MV:   state_nxt = ST_SAG1;
      ST_SAG1: state_nxt = ST_SAG2;
      ST_SAG2: state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = is_last ? ST_IDLE : ST_RD;
      ST_RL:   state_nxt = is_last ? ST_IDLE : ST_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop and memory write port.
  always_comb begin
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = upd_ent;
    unique case (state_r)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid && (cmd.kind == CMD_LOAD)) begin
          mem_we    = 1'b1;
          mem_waddr = cmd.index[AW-1:0];
          mem_wdata = load_ent;
        end
      end
      ST_UPD: mem_we = out_free;
      ST_RL: begin
        mem_we    = 1'b1;
        mem_wdata = rl_ent;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      loop_ended_r <= 1'b0;
      fin_r        <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The result register fills on a write-back and empties when taken.
      if (state_r == ST_UPD && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
      if (state_r == ST_IDLE && cmd_valid) begin
        idx_r <= '0;
        fin_r <= 1'b1;
        if (cmd.kind == CMD_END_LOOP) loop_ended_r <= 1'b1;
        if (cmd.kind == CMD_RESET_LIFE && cfg.looping) loop_ended_r <= 1'b0;
      end
      if (state_r == ST_RL) idx_r <= idx_r + 1'b1;
      if (state_r == ST_UPD && out_free) begin
        idx_r <= idx_r + 1'b1;
        fin_r <= fin_r & fin_this;
      end
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state_r == ST_RD) ent_r <= mem[idx_r];
  end

  // Arithmetic pipeline, square root and divider.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid) cmd_r <= cmd;
    unique case (state_r)
      ST_C1: begin
        dprod_r  <= 62'(ent_r.speed) * 62'(cmd_r.dt);
        s1prod_r <= 62'(ent_r.scale) * 62'(cfg.gravity);
        for (int k = 0; k < 3; k++) begin
          neg_r[k]  <= diff_c[k][32];
          mraw_r[k] <= mag_c[k][31:0];
        end
      end
      ST_C2: begin
        d_r  <= dsum[61:16];
        s1_r <= s1sum[61:16];
        for (int k = 0; k < 3; k++) begin
          ms_r[k] <= big_c ? 31'(mraw_r[k] >> 2) : mraw_r[k][30:0];
        end
      end
      ST_C3: begin
        s2prod_r <= 59'(s1_r) * 59'(Q_TENTH);
        for (int k = 0; k < 3; k++) sq_r[k] <= 62'(ms_r[k]) * 62'(ms_r[k]);
      end
      ST_C4: begin
        s2_r   <= s2sum[58:16];
        v_r    <= sq_t;
        r_r    <= 64'd0;
        bit_r  <= 64'h4000_0000_0000_0000;
        step_r <= 5'd0;
      end
      ST_SQRT: begin
        if (v_r >= r_r + bit_r) begin
          v_r <= v_r - (r_r + bit_r);
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 5'd1;
      end
      ST_LEN: begin
        len_r  <= r_r[31:0];
        step_r <= 5'd0;
        for (int k = 0; k < 3; k++) begin
          rem_r[k] <= 32'(num_c[k][47:17]);
          nsh_r[k] <= num_c[k][16:0];
          q_r[k]   <= 17'd0;
        end
      end
      ST_DIV: begin
        step_r <= step_r + 5'd1;
        for (int k = 0; k < 3; k++) begin
          rem_r[k] <= ge_c[k] ? 32'(rem2_c[k] - {1'b0, len_r}) : rem2_c[k][31:0];
          nsh_r[k] <= {nsh_r[k][15:0], 1'b0};
          q_r[k]   <= {q_r[k][15:0], ge_c[k]};
        end
      end
      ST_MV: begin
        // A particle on the pivot has no direction.
        for (int k = 0; k < 3; k++) begin
          mvp_r[k] <= (len_r == 32'd0) ? 63'd0 : 63'(q_r[k]) * 63'(d_r);
        end
      end
      ST_SAG1: begin
        for (int k = 0; k < 3; k++) mv_r[k] <= 47'((mvp_r[k] + 63'(Q_HALF)) >> 16);
        plo_r <= 64'(s2_r[31:0]) * 64'(ent_r.age);
        phi_r <= 43'(s2_r[42:32]) * 43'(ent_r.age);
      end
      ST_SAG2: begin
        if (mode_e != MODE_FRACTION)   sag_r <= 48'd0;
        else if (sag_q > 60'(MAG_CAP)) sag_r <= MAG_CAP;
        else                           sag_r <= sag_q[47:0];
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && out_free) begin
      out_data_r.result_index <= 6'(idx_r);
      out_data_r.pos_x        <= upd_ent.cur_x;
      out_data_r.pos_y        <= upd_ent.cur_y;
      out_data_r.pos_z        <= upd_ent.cur_z;
      out_data_r.last_result  <= is_last;
      out_data_r.all_finished <= is_last && fin_r && fin_this;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `ASSERT_CLK(a_fin_on_last, out_valid_r && out_data_r.all_finished |-> out_data_r.last_result, "all_finished set on a result that is not last")
  `ASSERT_CLK(a_upd_stall, state_r == ST_UPD && !out_free |=> state_r == ST_UPD, "update left while result register was full")

endmodule
